/* rtl/tpi_pkg.sv */
// shared widths and constants of the triangle plane interpolator
package tpi_pkg;

   localparam int COORD_BITS = 20;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = 32;

   // coordinate difference
   localparam int DW  = COORD_BITS + 1;
   // one cross product term
   localparam int XW  = 2 * DW;
   // plane coefficients a, b, c
   localparam int PW  = XW + 1;
   // products of a coefficient with a coordinate
   localparam int TW  = PW + DW;
   // unscaled numerator, then scaled numerator
   localparam int UW  = TW + 2;
   localparam int NW  = UW + FRAC_BITS;
   // depth sum of the three vertices
   localparam int SW  = COORD_BITS + 2;
   // quotient bits kept by the divider
   localparam int QB  = OUT_BITS;
   // remainder compare width
   localparam int RW  = ((NW > PW + QB) ? NW : PW + QB) + 1;

   localparam logic [PW-1:0] DEGEN_DIVISOR = PW'(3);

   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

endpackage

/* rtl/triangle_plane_interpolator.sv */
// top level of the triangle plane interpolator
// Each transaction carries a triangle (three vertices x, y, z) and a query point; the block
// returns the depth of the triangle's plane at that point with FRAC_BITS fraction bits,
// truncated toward zero and clamped to the signed output range (rsp_saturated set on a
// clamp). A triangle with no area in xy returns the mean vertex depth and sets
// rsp_degenerate. One transaction is accepted every cycle unless the output is stalled; the
// divider resolves one quotient bit per stage. The whole pipeline holds when a finished
// result is stalled at the output register, so req_stall follows rsp_stall while rsp_valid
// is high.
module triangle_plane_interpolator
   import tpi_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_v1_x,
   input  logic signed [COORD_BITS-1:0] req_v1_y,
   input  logic signed [COORD_BITS-1:0] req_v1_z,
   input  logic signed [COORD_BITS-1:0] req_v2_x,
   input  logic signed [COORD_BITS-1:0] req_v2_y,
   input  logic signed [COORD_BITS-1:0] req_v2_z,
   input  logic signed [COORD_BITS-1:0] req_v3_x,
   input  logic signed [COORD_BITS-1:0] req_v3_y,
   input  logic signed [COORD_BITS-1:0] req_v3_z,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_BITS-1:0]   rsp_depth_out,
   output logic                         rsp_degenerate,
   output logic                         rsp_saturated
);

   // global advance: everything moves unless the output holds a stalled transaction
   logic adv;

   // stage 1: differences
   logic                  s1_v_ff;
   logic signed [DW-1:0]  s1_dx2_ff, s1_dy2_ff, s1_dz2_ff, s1_dx3_ff, s1_dy3_ff, s1_dz3_ff;
   logic signed [DW-1:0]  s1_ex_ff, s1_ey_ff;
   logic signed [COORD_BITS-1:0] s1_z1_ff;
   logic signed [SW-1:0]  s1_zs_ff;

   // stage 2: cross product terms
   logic                  s2_v_ff;
   logic signed [XW-1:0]  s2_pa1_ff, s2_pa2_ff, s2_pb1_ff, s2_pb2_ff, s2_pc1_ff, s2_pc2_ff;
   logic signed [DW-1:0]  s2_ex_ff, s2_ey_ff;
   logic signed [COORD_BITS-1:0] s2_z1_ff;
   logic signed [SW-1:0]  s2_zs_ff;

   // stage 3: plane coefficients
   logic                  s3_v_ff;
   logic signed [PW-1:0]  s3_a_ff, s3_b_ff, s3_c_ff;
   logic signed [DW-1:0]  s3_ex_ff, s3_ey_ff;
   logic signed [COORD_BITS-1:0] s3_z1_ff;
   logic signed [SW-1:0]  s3_zs_ff;

   // stage 4: numerator products
   logic                  s4_v_ff;
   logic signed [TW-1:0]  s4_ta_ff, s4_tb_ff, s4_tc_ff;
   logic signed [PW-1:0]  s4_c_ff;
   logic                  s4_degen_ff;
   logic signed [SW-1:0]  s4_zs_ff;

   // stage 5: magnitudes and sign
   logic                  s5_v_ff;
   logic [NW-1:0]         s5_n_ff;
   logic [PW-1:0]         s5_d_ff;
   logic                  s5_neg_ff, s5_degen_ff;

   // divider pipeline, entry 0 is the range check stage
   logic                  dv_v_ff     [QB+1];
   logic [RW-1:0]         dv_r_ff     [QB+1];
   logic [PW-1:0]         dv_d_ff     [QB+1];
   logic [QB-1:0]         dv_q_ff     [QB+1];
   logic                  dv_neg_ff   [QB+1];
   logic                  dv_degen_ff [QB+1];
   logic                  dv_ovf_ff   [QB+1];

   // output register
   logic                  out_v_ff;
   logic signed [OUT_BITS-1:0] out_depth_ff;
   logic                  out_degen_ff, out_sat_ff;

   // stage 5 combinational
   logic signed [UW-1:0]  num_unscaled;
   logic signed [NW-1:0]  num_sel;
   logic [NW-1:0]         n_mag_in;
   logic [PW-1:0]         d_mag_in;
   logic                  neg_in;

   // output combinational
   logic [QB-1:0]         fq;
   logic                  sat_in;
   logic [OUT_BITS-1:0]   depth_in;

   assign adv       = !(out_v_ff && rsp_stall);
   assign req_stall = !adv;

   // numerator with the plane offset folded in: c*z1 - a*(qx-x1) - b*(qy-y1)
   always_comb begin
      num_unscaled = UW'(s4_tc_ff) - UW'(s4_ta_ff) - UW'(s4_tb_ff);
      if (s4_degen_ff) begin
         num_sel  = NW'(s4_zs_ff) <<< FRAC_BITS;
         d_mag_in = DEGEN_DIVISOR;
         neg_in   = num_sel[NW-1];
      end else begin
         num_sel  = NW'(num_unscaled) <<< FRAC_BITS;
         d_mag_in = s4_c_ff[PW-1] ? PW'(-s4_c_ff) : PW'(s4_c_ff);
         neg_in   = num_sel[NW-1] ^ s4_c_ff[PW-1];
      end
      n_mag_in = num_sel[NW-1] ? NW'(-num_sel) : NW'(num_sel);
   end

   // sign, range check and clamp on the final quotient
   always_comb begin
      fq = dv_q_ff[QB];
      sat_in = dv_ovf_ff[QB]
            || (!dv_neg_ff[QB] && fq[QB-1])
            || (dv_neg_ff[QB] && fq[QB-1] && (fq[QB-2:0] != '0));
      if (sat_in) begin
         depth_in = dv_neg_ff[QB] ? OUT_MIN : OUT_MAX;
      end else if (dv_neg_ff[QB]) begin
         depth_in = OUT_BITS'(-fq);
      end else begin
         depth_in = OUT_BITS'(fq);
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         s4_v_ff  <= 1'b0;
         s5_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) begin
            dv_v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         s3_v_ff    <= s2_v_ff;
         s4_v_ff    <= s3_v_ff;
         s5_v_ff    <= s4_v_ff;
         dv_v_ff[0] <= s5_v_ff;
         for (int k = 0; k < QB; k++) begin
            dv_v_ff[k+1] <= dv_v_ff[k];
         end
         out_v_ff   <= dv_v_ff[QB];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         s1_dx2_ff <= DW'(req_v2_x) - DW'(req_v1_x);
         s1_dy2_ff <= DW'(req_v2_y) - DW'(req_v1_y);
         s1_dz2_ff <= DW'(req_v2_z) - DW'(req_v1_z);
         s1_dx3_ff <= DW'(req_v3_x) - DW'(req_v1_x);
         s1_dy3_ff <= DW'(req_v3_y) - DW'(req_v1_y);
         s1_dz3_ff <= DW'(req_v3_z) - DW'(req_v1_z);
         s1_ex_ff  <= DW'(req_query_x) - DW'(req_v1_x);
         s1_ey_ff  <= DW'(req_query_y) - DW'(req_v1_y);
         s1_z1_ff  <= req_v1_z;
         s1_zs_ff  <= SW'(req_v1_z) + SW'(req_v2_z) + SW'(req_v3_z);
         // stage 2
         s2_pa1_ff <= s1_dy2_ff * s1_dz3_ff;
         s2_pa2_ff <= s1_dy3_ff * s1_dz2_ff;
         s2_pb1_ff <= s1_dz2_ff * s1_dx3_ff;
         s2_pb2_ff <= s1_dz3_ff * s1_dx2_ff;
         s2_pc1_ff <= s1_dx2_ff * s1_dy3_ff;
         s2_pc2_ff <= s1_dx3_ff * s1_dy2_ff;
         s2_ex_ff  <= s1_ex_ff;
         s2_ey_ff  <= s1_ey_ff;
         s2_z1_ff  <= s1_z1_ff;
         s2_zs_ff  <= s1_zs_ff;
         // stage 3
         s3_a_ff  <= PW'(s2_pa1_ff) - PW'(s2_pa2_ff);
         s3_b_ff  <= PW'(s2_pb1_ff) - PW'(s2_pb2_ff);
         s3_c_ff  <= PW'(s2_pc1_ff) - PW'(s2_pc2_ff);
         s3_ex_ff <= s2_ex_ff;
         s3_ey_ff <= s2_ey_ff;
         s3_z1_ff <= s2_z1_ff;
         s3_zs_ff <= s2_zs_ff;
         // stage 4
         s4_ta_ff    <= s3_a_ff * s3_ex_ff;
         s4_tb_ff    <= s3_b_ff * s3_ey_ff;
         s4_tc_ff    <= s3_c_ff * s3_z1_ff;
         s4_c_ff     <= s3_c_ff;
         s4_degen_ff <= (s3_c_ff == '0);
         s4_zs_ff    <= s3_zs_ff;
         // stage 5
         s5_n_ff     <= n_mag_in;
         s5_d_ff     <= d_mag_in;
         s5_neg_ff   <= neg_in;
         s5_degen_ff <= s4_degen_ff;
         // range check: quotient must stay below 2^QB
         dv_r_ff[0]     <= RW'(s5_n_ff);
         dv_d_ff[0]     <= s5_d_ff;
         dv_q_ff[0]     <= '0;
         dv_neg_ff[0]   <= s5_neg_ff;
         dv_degen_ff[0] <= s5_degen_ff;
         dv_ovf_ff[0]   <= (RW'(s5_n_ff) >= (RW'(s5_d_ff) << QB));
         // one quotient bit per stage, most significant first
         for (int k = 0; k < QB; k++) begin
            if (!dv_ovf_ff[k] && (dv_r_ff[k] >= (RW'(dv_d_ff[k]) << (QB - 1 - k)))) begin
               dv_r_ff[k+1] <= dv_r_ff[k] - (RW'(dv_d_ff[k]) << (QB - 1 - k));
               dv_q_ff[k+1] <= dv_q_ff[k] | (QB'(1) << (QB - 1 - k));
            end else begin
               dv_r_ff[k+1] <= dv_r_ff[k];
               dv_q_ff[k+1] <= dv_q_ff[k];
            end
            dv_d_ff[k+1]     <= dv_d_ff[k];
            dv_neg_ff[k+1]   <= dv_neg_ff[k];
            dv_degen_ff[k+1] <= dv_degen_ff[k];
            dv_ovf_ff[k+1]   <= dv_ovf_ff[k];
         end
         // output
         out_depth_ff <= depth_in;
         out_degen_ff <= dv_degen_ff[QB];
         out_sat_ff   <= sat_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_depth_out  = out_depth_ff;
   assign rsp_degenerate = out_degen_ff;
   assign rsp_saturated  = out_sat_ff;

endmodule

/* rtl/tpi_checker.sv */
// port level checks of the triangle plane interpolator and their binding
module tpi_checker
   import tpi_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [OUT_BITS-1:0] rsp_depth_out,
   input logic                       rsp_degenerate,
   input logic                       rsp_saturated
);

   // a stalled result transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_depth_out))
      else $error("stalled result changed");

   // input stalls exactly when a finished result is held
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow output stall");

   // a clamped depth sits on a range bound
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> (rsp_depth_out == OUT_MAX) || (rsp_depth_out == OUT_MIN))
      else $error("saturated depth not at a bound");

   // the vertex mean always fits
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> !rsp_saturated)
      else $error("degenerate mean flagged as saturated");

endmodule

bind triangle_plane_interpolator tpi_checker u_tpi_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_depth_out (rsp_depth_out),
   .rsp_degenerate(rsp_degenerate),
   .rsp_saturated (rsp_saturated)
);
